FILE: src/ppe_pkg.sv
package ppe_pkg;

   // Pool geometry
   localparam int SLOT_COUNT = 32;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   // Field widths
   localparam int AGE_W      = 9;
   localparam int POS_W      = 16;
   localparam int VEL_W      = 8;
   localparam int MAX_AGE_W  = 8;
   localparam int FCFG_W     = 5;
   localparam int FRAME_W    = 4;
   localparam int SLOT_OUT_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Divider: one quotient bit per step over the age width
   localparam int STEP_W = $clog2(AGE_W + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AGE_W - 1);
   localparam int TRIAL_W = FCFG_W + 1;
   localparam int DIFF_W  = FCFG_W + 2;

   // Item kinds and particle types
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_TICK  = 1'b1;
   localparam logic TYPE_SMOKE = 1'b0;
   localparam logic TYPE_BOOST = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SMOKE_MAX_AGE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOKE_FRAME_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOKE_FRAME_DELAY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_MAX_AGE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_FRAME_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_FRAME_DELAY = 3'd5;

   // Register reset values
   localparam logic [MAX_AGE_W-1:0] RST_SMOKE_MAX_AGE     = 8'd12;
   localparam logic [FCFG_W-1:0]    RST_SMOKE_FRAME_COUNT = 5'd3;
   localparam logic [FCFG_W-1:0]    RST_SMOKE_FRAME_DELAY = 5'd4;
   localparam logic [MAX_AGE_W-1:0] RST_BOOST_MAX_AGE     = 8'd20;
   localparam logic [FCFG_W-1:0]    RST_BOOST_FRAME_COUNT = 5'd5;
   localparam logic [FCFG_W-1:0]    RST_BOOST_FRAME_DELAY = 5'd4;

   // One stored particle
   typedef struct packed {
      logic                 ptype;
      logic [AGE_W-1:0]     age;
      logic [POS_W-1:0]     x;
      logic [POS_W-1:0]     y;
      logic [VEL_W-1:0]     vx;
      logic [VEL_W-1:0]     vy;
   } slot_rec_type;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_ADD_SCAN   = 9'b000000010,
      ST_ADD_EMIT   = 9'b000000100,
      ST_TICK_READ  = 9'b000001000,
      ST_TICK_EVAL  = 9'b000010000,
      ST_DIV_Q      = 9'b000100000,
      ST_DIV_R      = 9'b001000000,
      ST_TICK_EMIT  = 9'b010000000,
      ST_TICK_CLOSE = 9'b100000000
   } state_type;

endpackage

FILE: src/particle_pool_engine.sv
// Particle pool engine: a fixed pool of particle slots.
// Input channel (req_*): one beat is an add (req_kind 0) or a tick (req_kind 1).
// An add scans the slots from zero, one per cycle, claims the lowest free one
// and answers with one beat (add_done with the slot, or pool_full), marked last.
// A tick walks every slot, one per cycle when free. An active slot is read from
// the slot memory, retired silently if its age is past its type's limit, or
// aged and moved and then given an animation frame by a shared restoring
// divider: nine steps for age / delay, nine more for quotient mod count.
// A drawn slot passes the read, evaluate, divide and emit states (the second divide
// is skipped when its frame count is zero), a retired slot read and evaluate, and a
// free slot read only; a tick ends in a closing beat with last set.
// req_ready is high only while the sequencer is idle; the last result may still
// sit in the output register then, so the next item is taken meanwhile.
// The result channel (rsp_*) is one output register: a stalled receiver holds
// the beat and the sequencer waits at its next result.
// Configuration (csr_*) is always ready; write it only while the block is idle.
// Reset frees every slot and loads the register defaults; no clearing pass.
module particle_pool_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic                                req_particle_type,
   input  logic signed [ppe_pkg::POS_W-1:0]    req_start_x,
   input  logic signed [ppe_pkg::POS_W-1:0]    req_start_y,
   input  logic signed [ppe_pkg::VEL_W-1:0]    req_vel_x,
   input  logic signed [ppe_pkg::VEL_W-1:0]    req_vel_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_draw_valid,
   output logic [ppe_pkg::SLOT_OUT_W-1:0]      rsp_slot_index,
   output logic                                rsp_drawn_type,
   output logic [ppe_pkg::FRAME_W-1:0]         rsp_frame_index,
   output logic signed [ppe_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [ppe_pkg::POS_W-1:0]    rsp_pos_y,
   output logic                                rsp_add_done,
   output logic                                rsp_pool_full,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppe_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Control registers
   ppe_pkg::state_type state_ff, state_in;
   logic [ppe_pkg::SLOT_COUNT-1:0] active_ff, active_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ppe_pkg::MAX_AGE_W-1:0] smoke_max_age_ff, smoke_max_age_in;
   logic [ppe_pkg::FCFG_W-1:0] smoke_count_ff, smoke_count_in;
   logic [ppe_pkg::FCFG_W-1:0] smoke_delay_ff, smoke_delay_in;
   logic [ppe_pkg::MAX_AGE_W-1:0] boost_max_age_ff, boost_max_age_in;
   logic [ppe_pkg::FCFG_W-1:0] boost_count_ff, boost_count_in;
   logic [ppe_pkg::FCFG_W-1:0] boost_delay_ff, boost_delay_in;

   // Working registers
   logic [ppe_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic type_ff, type_in;
   logic [ppe_pkg::POS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ppe_pkg::VEL_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic full_ff, full_in;
   logic [ppe_pkg::AGE_W-1:0] quo_ff, quo_in;
   logic [ppe_pkg::FCFG_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [ppe_pkg::STEP_W-1:0] step_ff, step_in;
   logic [ppe_pkg::FRAME_W-1:0] frame_ff, frame_in;

   // Output payload registers
   logic out_draw_ff, out_draw_in;
   logic [ppe_pkg::SLOT_OUT_W-1:0] out_slot_ff, out_slot_in;
   logic out_type_ff, out_type_in;
   logic [ppe_pkg::FRAME_W-1:0] out_frame_ff, out_frame_in;
   logic [ppe_pkg::POS_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic out_done_ff, out_done_in;
   logic out_full_ff, out_full_in;
   logic out_last_ff, out_last_in;

   // Slot memory
   ppe_pkg::slot_rec_type slot_mem [ppe_pkg::SLOT_COUNT];
   ppe_pkg::slot_rec_type mem_rd_ff;
   ppe_pkg::slot_rec_type mem_wd;
   logic mem_we, mem_re;

   // Shared divider step and per-type selections
   logic [ppe_pkg::TRIAL_W-1:0] trial;
   logic [ppe_pkg::DIFF_W-1:0] diff;
   logic fits;
   logic [ppe_pkg::FCFG_W-1:0] step_rem;
   logic [ppe_pkg::AGE_W-1:0] step_quo;
   logic [ppe_pkg::MAX_AGE_W-1:0] sel_max_age;
   logic [ppe_pkg::FCFG_W-1:0] sel_delay, sel_count;
   logic out_free, slot_is_last;
   logic [ppe_pkg::AGE_W-1:0] new_age;

   assign req_ready       = (state_ff == ppe_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_draw_valid  = out_draw_ff;
   assign rsp_slot_index  = out_slot_ff;
   assign rsp_drawn_type  = out_type_ff;
   assign rsp_frame_index = out_frame_ff;
   assign rsp_pos_x       = out_x_ff;
   assign rsp_pos_y       = out_y_ff;
   assign rsp_add_done    = out_done_ff;
   assign rsp_pool_full   = out_full_ff;
   assign rsp_last        = out_last_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign slot_is_last = (slot_ff == ppe_pkg::LAST_SLOT);

   // Restoring divide step: shift in one dividend bit, subtract if it fits
   assign trial    = {rem_ff, quo_ff[ppe_pkg::AGE_W-1]};
   assign diff     = {1'b0, trial} - {2'b00, div_ff};
   assign fits     = !diff[ppe_pkg::DIFF_W-1];
   assign step_rem = fits ? diff[ppe_pkg::FCFG_W-1:0] : trial[ppe_pkg::FCFG_W-1:0];
   assign step_quo = {quo_ff[ppe_pkg::AGE_W-2:0], fits};

   // Pick the limits of the particle being handled
   always_comb begin
      if (state_ff == ppe_pkg::ST_TICK_EVAL) begin
         sel_max_age = (mem_rd_ff.ptype == ppe_pkg::TYPE_BOOST) ? boost_max_age_ff
                                                                 : smoke_max_age_ff;
         sel_delay   = (mem_rd_ff.ptype == ppe_pkg::TYPE_BOOST) ? boost_delay_ff
                                                                 : smoke_delay_ff;
      end else begin
         sel_max_age = (type_ff == ppe_pkg::TYPE_BOOST) ? boost_max_age_ff
                                                         : smoke_max_age_ff;
         sel_delay   = (type_ff == ppe_pkg::TYPE_BOOST) ? boost_delay_ff
                                                         : smoke_delay_ff;
      end
      sel_count = (type_ff == ppe_pkg::TYPE_BOOST) ? boost_count_ff : smoke_count_ff;
   end

   assign new_age = mem_rd_ff.age + ppe_pkg::AGE_W'(1);

   // Sequencer and next values
   always_comb begin
      state_in         = state_ff;
      active_in        = active_ff;
      rsp_valid_in     = rsp_valid_ff;
      smoke_max_age_in = smoke_max_age_ff;
      smoke_count_in   = smoke_count_ff;
      smoke_delay_in   = smoke_delay_ff;
      boost_max_age_in = boost_max_age_ff;
      boost_count_in   = boost_count_ff;
      boost_delay_in   = boost_delay_ff;
      slot_in          = slot_ff;
      type_in          = type_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      vx_in            = vx_ff;
      vy_in            = vy_ff;
      full_in          = full_ff;
      quo_in           = quo_ff;
      rem_in           = rem_ff;
      div_in           = div_ff;
      step_in          = step_ff;
      frame_in         = frame_ff;
      out_draw_in      = out_draw_ff;
      out_slot_in      = out_slot_ff;
      out_type_in      = out_type_ff;
      out_frame_in     = out_frame_ff;
      out_x_in         = out_x_ff;
      out_y_in         = out_y_ff;
      out_done_in      = out_done_ff;
      out_full_in      = out_full_ff;
      out_last_in      = out_last_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_wd           = mem_rd_ff;

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            ppe_pkg::CSR_SMOKE_MAX_AGE:     smoke_max_age_in = csr_data;
            ppe_pkg::CSR_SMOKE_FRAME_COUNT: smoke_count_in = csr_data[ppe_pkg::FCFG_W-1:0];
            ppe_pkg::CSR_SMOKE_FRAME_DELAY: smoke_delay_in = csr_data[ppe_pkg::FCFG_W-1:0];
            ppe_pkg::CSR_BOOST_MAX_AGE:     boost_max_age_in = csr_data;
            ppe_pkg::CSR_BOOST_FRAME_COUNT: boost_count_in = csr_data[ppe_pkg::FCFG_W-1:0];
            ppe_pkg::CSR_BOOST_FRAME_DELAY: boost_delay_in = csr_data[ppe_pkg::FCFG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ppe_pkg::ST_IDLE: begin
            if (req_valid) begin
               type_in = req_particle_type;
               x_in    = req_start_x;
               y_in    = req_start_y;
               vx_in   = req_vel_x;
               vy_in   = req_vel_y;
               slot_in = '0;
               state_in = (req_kind == ppe_pkg::KIND_TICK) ? ppe_pkg::ST_TICK_READ
                                                           : ppe_pkg::ST_ADD_SCAN;
            end
         end

         // Find the lowest free slot, one per cycle
         ppe_pkg::ST_ADD_SCAN: begin
            if (!active_ff[slot_ff]) begin
               mem_we             = 1'b1;
               mem_wd.ptype       = type_ff;
               mem_wd.age         = '0;
               mem_wd.x           = x_ff;
               mem_wd.y           = y_ff;
               mem_wd.vx          = vx_ff;
               mem_wd.vy          = vy_ff;
               active_in[slot_ff] = 1'b1;
               full_in            = 1'b0;
               state_in           = ppe_pkg::ST_ADD_EMIT;
            end else if (slot_is_last) begin
               full_in  = 1'b1;
               state_in = ppe_pkg::ST_ADD_EMIT;
            end else begin
               slot_in = slot_ff + ppe_pkg::SLOT_W'(1);
            end
         end

         ppe_pkg::ST_ADD_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_draw_in  = 1'b0;
               out_slot_in  = full_ff ? '0 : ppe_pkg::SLOT_OUT_W'(slot_ff);
               out_type_in  = 1'b0;
               out_frame_in = '0;
               out_x_in     = '0;
               out_y_in     = '0;
               out_done_in  = !full_ff;
               out_full_in  = full_ff;
               out_last_in  = 1'b1;
               state_in     = ppe_pkg::ST_IDLE;
            end
         end

         // Skip free slots, fetch live ones
         ppe_pkg::ST_TICK_READ: begin
            if (active_ff[slot_ff]) begin
               mem_re   = 1'b1;
               state_in = ppe_pkg::ST_TICK_EVAL;
            end else if (slot_is_last) begin
               state_in = ppe_pkg::ST_TICK_CLOSE;
            end else begin
               slot_in = slot_ff + ppe_pkg::SLOT_W'(1);
            end
         end

         // Retire an old particle, or age and move it and start the divide
         ppe_pkg::ST_TICK_EVAL: begin
            if (mem_rd_ff.age > {1'b0, sel_max_age}) begin
               active_in[slot_ff] = 1'b0;
               if (slot_is_last) begin
                  state_in = ppe_pkg::ST_TICK_CLOSE;
               end else begin
                  slot_in  = slot_ff + ppe_pkg::SLOT_W'(1);
                  state_in = ppe_pkg::ST_TICK_READ;
               end
            end else begin
               mem_we     = 1'b1;
               mem_wd.age = new_age;
               mem_wd.x   = mem_rd_ff.x +
                            {{(ppe_pkg::POS_W-ppe_pkg::VEL_W){mem_rd_ff.vx[ppe_pkg::VEL_W-1]}},
                             mem_rd_ff.vx};
               mem_wd.y   = mem_rd_ff.y +
                            {{(ppe_pkg::POS_W-ppe_pkg::VEL_W){mem_rd_ff.vy[ppe_pkg::VEL_W-1]}},
                             mem_rd_ff.vy};
               x_in       = mem_wd.x;
               y_in       = mem_wd.y;
               type_in    = mem_rd_ff.ptype;
               quo_in     = new_age;
               rem_in     = '0;
               div_in     = (sel_delay == '0) ? ppe_pkg::FCFG_W'(1) : sel_delay;
               step_in    = '0;
               state_in   = ppe_pkg::ST_DIV_Q;
            end
         end

         // age / delay
         ppe_pkg::ST_DIV_Q: begin
            quo_in  = step_quo;
            rem_in  = step_rem;
            step_in = step_ff + ppe_pkg::STEP_W'(1);
            if (step_ff == ppe_pkg::LAST_STEP) begin
               if (sel_count == '0) begin
                  frame_in = '0;
                  state_in = ppe_pkg::ST_TICK_EMIT;
               end else begin
                  rem_in   = '0;
                  div_in   = sel_count;
                  step_in  = '0;
                  state_in = ppe_pkg::ST_DIV_R;
               end
            end
         end

         // quotient mod count
         ppe_pkg::ST_DIV_R: begin
            quo_in  = step_quo;
            rem_in  = step_rem;
            step_in = step_ff + ppe_pkg::STEP_W'(1);
            if (step_ff == ppe_pkg::LAST_STEP) begin
               frame_in = step_rem[ppe_pkg::FRAME_W-1:0];
               state_in = ppe_pkg::ST_TICK_EMIT;
            end
         end

         ppe_pkg::ST_TICK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_draw_in  = 1'b1;
               out_slot_in  = ppe_pkg::SLOT_OUT_W'(slot_ff);
               out_type_in  = type_ff;
               out_frame_in = frame_ff;
               out_x_in     = x_ff;
               out_y_in     = y_ff;
               out_done_in  = 1'b0;
               out_full_in  = 1'b0;
               out_last_in  = 1'b0;
               if (slot_is_last) begin
                  state_in = ppe_pkg::ST_TICK_CLOSE;
               end else begin
                  slot_in  = slot_ff + ppe_pkg::SLOT_W'(1);
                  state_in = ppe_pkg::ST_TICK_READ;
               end
            end
         end

         ppe_pkg::ST_TICK_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_draw_in  = 1'b0;
               out_slot_in  = '0;
               out_type_in  = 1'b0;
               out_frame_in = '0;
               out_x_in     = '0;
               out_y_in     = '0;
               out_done_in  = 1'b0;
               out_full_in  = 1'b0;
               out_last_in  = 1'b1;
               state_in     = ppe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ppe_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ppe_pkg::ST_IDLE;
         active_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         smoke_max_age_ff <= ppe_pkg::RST_SMOKE_MAX_AGE;
         smoke_count_ff   <= ppe_pkg::RST_SMOKE_FRAME_COUNT;
         smoke_delay_ff   <= ppe_pkg::RST_SMOKE_FRAME_DELAY;
         boost_max_age_ff <= ppe_pkg::RST_BOOST_MAX_AGE;
         boost_count_ff   <= ppe_pkg::RST_BOOST_FRAME_COUNT;
         boost_delay_ff   <= ppe_pkg::RST_BOOST_FRAME_DELAY;
         step_ff          <= '0;
      end else begin
         state_ff         <= state_in;
         active_ff        <= active_in;
         rsp_valid_ff     <= rsp_valid_in;
         smoke_max_age_ff <= smoke_max_age_in;
         smoke_count_ff   <= smoke_count_in;
         smoke_delay_ff   <= smoke_delay_in;
         boost_max_age_ff <= boost_max_age_in;
         boost_count_ff   <= boost_count_in;
         boost_delay_ff   <= boost_delay_in;
         step_ff          <= step_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      type_ff      <= type_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      full_ff      <= full_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      frame_ff     <= frame_in;
      out_draw_ff  <= out_draw_in;
      out_slot_ff  <= out_slot_in;
      out_type_ff  <= out_type_in;
      out_frame_ff <= out_frame_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_done_ff  <= out_done_in;
      out_full_ff  <= out_full_in;
      out_last_ff  <= out_last_in;
   end

   // Slot memory: one write, one registered read, both at the current slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[slot_ff] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= slot_mem[slot_ff];
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted item always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ppe_pkg::ST_IDLE)
      else $error("accepted item did not start the sequencer");

   // Only a live slot is evaluated
   a_eval_live_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ppe_pkg::ST_TICK_EVAL |-> active_ff[slot_ff])
      else $error("evaluating a free slot");

   // Divider step count stays within the dividend width
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppe_pkg::ST_DIV_Q || state_ff == ppe_pkg::ST_DIV_R)
      |-> step_ff <= ppe_pkg::LAST_STEP)
      else $error("divider ran past its last step");

   // A draw beat never closes an item nor carries add status
   a_draw_beat_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_draw_ff |-> !out_last_ff && !out_done_ff && !out_full_ff)
      else $error("draw beat with last or add status");

   // An add reports stored or full, never both
   a_add_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_done_ff && out_full_ff))
      else $error("add beat both done and full");
`endif

endmodule

FILE: tb/particle_pool_engine_tb.sv
module particle_pool_engine_tb;

   localparam int STUCK_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;
   localparam int GAP_MAX     = 19;
   localparam int FIELD_W     = ppe_pkg::POS_W;

   // Register indexes the block does not decode
   localparam logic [ppe_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ppe_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic                      kind;
      logic                      ptype;
      logic [ppe_pkg::POS_W-1:0] sx;
      logic [ppe_pkg::POS_W-1:0] sy;
      logic [ppe_pkg::VEL_W-1:0] vx;
      logic [ppe_pkg::VEL_W-1:0] vy;
   } pool_cmd_type;

   typedef struct {
      logic                           draw_valid;
      logic [ppe_pkg::SLOT_OUT_W-1:0] slot_index;
      logic                           drawn_type;
      logic [ppe_pkg::FRAME_W-1:0]    frame_index;
      logic [ppe_pkg::POS_W-1:0]      pos_x;
      logic [ppe_pkg::POS_W-1:0]      pos_y;
      logic                           add_done;
      logic                           pool_full;
      logic                           last;
   } pool_beat_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_kind = ppe_pkg::KIND_ADD;
   logic                                req_particle_type = ppe_pkg::TYPE_SMOKE;
   logic signed [ppe_pkg::POS_W-1:0]    req_start_x = '0;
   logic signed [ppe_pkg::POS_W-1:0]    req_start_y = '0;
   logic signed [ppe_pkg::VEL_W-1:0]    req_vel_x = '0;
   logic signed [ppe_pkg::VEL_W-1:0]    req_vel_y = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_draw_valid;
   logic [ppe_pkg::SLOT_OUT_W-1:0]      rsp_slot_index;
   logic                                rsp_drawn_type;
   logic [ppe_pkg::FRAME_W-1:0]         rsp_frame_index;
   logic signed [ppe_pkg::POS_W-1:0]    rsp_pos_x;
   logic signed [ppe_pkg::POS_W-1:0]    rsp_pos_y;
   logic                                rsp_add_done;
   logic                                rsp_pool_full;
   logic                                rsp_last;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [ppe_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [ppe_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   // Shadow of the pool and its registers
   logic                          pool_live [ppe_pkg::SLOT_COUNT] = '{default: 1'b0};
   logic [ppe_pkg::AGE_W-1:0]     pool_age  [ppe_pkg::SLOT_COUNT];
   logic                          pool_type [ppe_pkg::SLOT_COUNT];
   logic [ppe_pkg::POS_W-1:0]     pool_x    [ppe_pkg::SLOT_COUNT];
   logic [ppe_pkg::POS_W-1:0]     pool_y    [ppe_pkg::SLOT_COUNT];
   logic [ppe_pkg::VEL_W-1:0]     pool_vx   [ppe_pkg::SLOT_COUNT];
   logic [ppe_pkg::VEL_W-1:0]     pool_vy   [ppe_pkg::SLOT_COUNT];
   logic [ppe_pkg::MAX_AGE_W-1:0] cfg_max_age [2] =
      '{ppe_pkg::RST_SMOKE_MAX_AGE, ppe_pkg::RST_BOOST_MAX_AGE};
   logic [ppe_pkg::FCFG_W-1:0]    cfg_frame_count [2] =
      '{ppe_pkg::RST_SMOKE_FRAME_COUNT, ppe_pkg::RST_BOOST_FRAME_COUNT};
   logic [ppe_pkg::FCFG_W-1:0]    cfg_frame_delay [2] =
      '{ppe_pkg::RST_SMOKE_FRAME_DELAY, ppe_pkg::RST_BOOST_FRAME_DELAY};

   pool_cmd_type  pending_cmds [$];
   pool_beat_type expected_beats [$];
   pool_cmd_type  req_beat;
   int         items_queued = 0;
   int         items_taken = 0;
   int         error_count = 0;
   int         req_gap_max = GAP_MAX;
   int         rsp_gap_max = GAP_MAX;
   int         req_gap_left = 0;
   int         rsp_stall_left = 0;
   int         hold_left = 0;
   logic       hold_request = 1'b0;
   int         stuck_cycles = 0;

   particle_pool_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_particle_type (req_particle_type),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_draw_valid    (rsp_draw_valid),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_drawn_type    (rsp_drawn_type),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_add_done      (rsp_add_done),
      .rsp_pool_full     (rsp_pool_full),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one accepted item to the shadow pool and queue the beats it causes
   function automatic void advance_pool_model(pool_cmd_type cmd);
      pool_beat_type beat;
      int         slot;
      int         divisor;
      int         count;
      logic       t;
      slot = -1;
      if (cmd.kind == ppe_pkg::KIND_ADD) begin
         for (int i = 0; i < ppe_pkg::SLOT_COUNT; i++)
            if (slot < 0 && !pool_live[i]) slot = i;
         beat = '{default: '0};
         beat.last = 1'b1;
         if (slot < 0) begin
            beat.pool_full = 1'b1;
         end else begin
            pool_live[slot] = 1'b1;
            pool_type[slot] = cmd.ptype;
            pool_x[slot]    = cmd.sx;
            pool_y[slot]    = cmd.sy;
            pool_vx[slot]   = cmd.vx;
            pool_vy[slot]   = cmd.vy;
            pool_age[slot]  = '0;
            beat.add_done   = 1'b1;
            beat.slot_index = ppe_pkg::SLOT_OUT_W'(slot);
         end
         expected_beats.push_back(beat);
      end else begin
         for (int i = 0; i < ppe_pkg::SLOT_COUNT; i++) begin
            if (pool_live[i]) begin
               t = pool_type[i];
               // retire silently once past the type's age limit
               if (pool_age[i] > cfg_max_age[t]) begin
                  pool_live[i] = 1'b0;
               end else begin
                  pool_age[i] = pool_age[i] + ppe_pkg::AGE_W'(1);
                  pool_x[i] = pool_x[i] +
                     {{(ppe_pkg::POS_W-ppe_pkg::VEL_W){pool_vx[i][ppe_pkg::VEL_W-1]}},
                      pool_vx[i]};
                  pool_y[i] = pool_y[i] +
                     {{(ppe_pkg::POS_W-ppe_pkg::VEL_W){pool_vy[i][ppe_pkg::VEL_W-1]}},
                      pool_vy[i]};
                  divisor = (cfg_frame_delay[t] == 0) ? 1 : int'(cfg_frame_delay[t]);
                  count = int'(cfg_frame_count[t]);
                  beat = '{default: '0};
                  beat.draw_valid  = 1'b1;
                  beat.slot_index  = ppe_pkg::SLOT_OUT_W'(i);
                  beat.drawn_type  = t;
                  beat.frame_index = (count == 0) ? '0 :
                     ppe_pkg::FRAME_W'((int'(pool_age[i]) / divisor) % count);
                  beat.pos_x = pool_x[i];
                  beat.pos_y = pool_y[i];
                  expected_beats.push_back(beat);
               end
            end
         end
         beat = '{default: '0};
         beat.last = 1'b1;
         expected_beats.push_back(beat);
      end
   endfunction

   function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                       logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Driver: offer queued items, draw an idle gap after each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_pool_model(req_beat);
            items_taken++;
            req_gap_left = $urandom_range(0, req_gap_max);
         end
         if (!req_valid || req_ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               req_beat = pending_cmds.pop_front();
               req_valid         <= 1'b1;
               req_kind          <= req_beat.kind;
               req_particle_type <= req_beat.ptype;
               req_start_x       <= req_beat.sx;
               req_start_y       <= req_beat.sy;
               req_vel_x         <= req_beat.vx;
               req_vel_y         <= req_beat.vy;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat, then stall or hold off the receiver
   always @(posedge clock) begin
      pool_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual slot %0d last %0b",
                        $time, rsp_slot_index, rsp_last);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("draw_valid", FIELD_W'(want.draw_valid),
                           FIELD_W'(rsp_draw_valid));
               check_field("slot_index", FIELD_W'(want.slot_index),
                           FIELD_W'(rsp_slot_index));
               check_field("drawn_type", FIELD_W'(want.drawn_type),
                           FIELD_W'(rsp_drawn_type));
               check_field("frame_index", FIELD_W'(want.frame_index),
                           FIELD_W'(rsp_frame_index));
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("add_done", FIELD_W'(want.add_done), FIELD_W'(rsp_add_done));
               check_field("pool_full", FIELD_W'(want.pool_full), FIELD_W'(rsp_pool_full));
               check_field("last", FIELD_W'(want.last), FIELD_W'(rsp_last));
            end
            rsp_stall_left = $urandom_range(0, rsp_gap_max);
         end
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic push_add(input logic ptype, input logic [ppe_pkg::POS_W-1:0] sx,
                           input logic [ppe_pkg::POS_W-1:0] sy,
                           input logic [ppe_pkg::VEL_W-1:0] vx,
                           input logic [ppe_pkg::VEL_W-1:0] vy);
      pool_cmd_type cmd;
      cmd = '{ppe_pkg::KIND_ADD, ptype, sx, sy, vx, vy};
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   task automatic push_tick();
      pool_cmd_type cmd;
      cmd = '{ppe_pkg::KIND_TICK, 1'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom), 8'($urandom)};
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   // Write one register and mirror it once the beat is taken
   task automatic write_reg(input logic [ppe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ppe_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         ppe_pkg::CSR_SMOKE_MAX_AGE:
            cfg_max_age[ppe_pkg::TYPE_SMOKE] = val;
         ppe_pkg::CSR_SMOKE_FRAME_COUNT:
            cfg_frame_count[ppe_pkg::TYPE_SMOKE] = val[ppe_pkg::FCFG_W-1:0];
         ppe_pkg::CSR_SMOKE_FRAME_DELAY:
            cfg_frame_delay[ppe_pkg::TYPE_SMOKE] = val[ppe_pkg::FCFG_W-1:0];
         ppe_pkg::CSR_BOOST_MAX_AGE:
            cfg_max_age[ppe_pkg::TYPE_BOOST] = val;
         ppe_pkg::CSR_BOOST_FRAME_COUNT:
            cfg_frame_count[ppe_pkg::TYPE_BOOST] = val[ppe_pkg::FCFG_W-1:0];
         ppe_pkg::CSR_BOOST_FRAME_DELAY:
            cfg_frame_delay[ppe_pkg::TYPE_BOOST] = val[ppe_pkg::FCFG_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued item is taken and every result has come back
   task automatic wait_idle();
      @(posedge clock);
      while (items_taken != items_queued || expected_beats.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int                            burst;
      int                            phase_items;
      logic [ppe_pkg::MAX_AGE_W-1:0] age_lim;
      logic [ppe_pkg::FCFG_W-1:0]    fcount;
      logic [ppe_pkg::FCFG_W-1:0]    fdelay;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default registers: empty tick, field extremes, wrap on the next ticks
      push_tick();
      push_add(ppe_pkg::TYPE_SMOKE, 16'h7FFF, 16'h8000, 8'h7F, 8'h80);
      push_add(ppe_pkg::TYPE_BOOST, 16'h8000, 16'h7FFF, 8'h80, 8'h7F);
      push_add(ppe_pkg::TYPE_SMOKE, 16'h0000, 16'h0000, 8'h00, 8'h00);
      push_add(ppe_pkg::TYPE_BOOST, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      push_tick();
      push_tick();
      wait_idle();

      // Zero age limit, zero frame count, zero delay, frames past fifteen
      write_reg(ppe_pkg::CSR_SMOKE_MAX_AGE, 8'd0);
      write_reg(ppe_pkg::CSR_SMOKE_FRAME_COUNT, 8'd0);
      write_reg(ppe_pkg::CSR_SMOKE_FRAME_DELAY, 8'd0);
      write_reg(ppe_pkg::CSR_BOOST_MAX_AGE, 8'd40);
      write_reg(ppe_pkg::CSR_BOOST_FRAME_COUNT, 8'd31);
      write_reg(ppe_pkg::CSR_BOOST_FRAME_DELAY, 8'd0);
      write_reg(CSR_SPARE_LO, 8'hFF);
      write_reg(CSR_SPARE_HI, 8'h00);
      push_tick();
      push_add(ppe_pkg::TYPE_SMOKE, 16'h1234, 16'hEDCB, 8'h05, 8'hFB);
      push_add(ppe_pkg::TYPE_BOOST, 16'h7FF0, 16'h8010, 8'h7F, 8'h81);
      repeat (16) push_tick();
      wait_idle();

      // Overfill the pool while the receiver holds off; the input must stall
      write_reg(ppe_pkg::CSR_SMOKE_MAX_AGE, 8'd255);
      write_reg(ppe_pkg::CSR_SMOKE_FRAME_COUNT, 8'd16);
      write_reg(ppe_pkg::CSR_SMOKE_FRAME_DELAY, 8'd16);
      write_reg(ppe_pkg::CSR_BOOST_MAX_AGE, 8'd255);
      write_reg(ppe_pkg::CSR_BOOST_FRAME_COUNT, 8'd1);
      write_reg(ppe_pkg::CSR_BOOST_FRAME_DELAY, 8'd1);
      req_gap_max = 0;
      hold_request = 1'b1;
      repeat (36) push_add(1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                           8'($urandom));
      repeat (3) push_tick();
      wait_idle();

      // Random phases: add bursts then ticks, random registers and idling
      for (int p = 0; p < 4; p++) begin
         for (int t = 0; t < 2; t++) begin
            case ($urandom_range(0, 3))
               0:       age_lim = 8'd0;
               1:       age_lim = 8'd255;
               default: age_lim = 8'($urandom_range(1, 40));
            endcase
            fcount = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) :
                                                   5'($urandom_range(0, 16));
            fdelay = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(5, 31)) :
                                                   5'($urandom_range(0, 4));
            write_reg((t == 0) ? ppe_pkg::CSR_SMOKE_MAX_AGE : ppe_pkg::CSR_BOOST_MAX_AGE,
                      age_lim);
            write_reg((t == 0) ? ppe_pkg::CSR_SMOKE_FRAME_COUNT
                               : ppe_pkg::CSR_BOOST_FRAME_COUNT,
                      {3'($urandom), fcount});
            write_reg((t == 0) ? ppe_pkg::CSR_SMOKE_FRAME_DELAY
                               : ppe_pkg::CSR_BOOST_FRAME_DELAY,
                      {3'($urandom), fdelay});
         end
         req_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
         rsp_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
         phase_items = 0;
         while (phase_items < 22) begin
            burst = $urandom_range(1, 8);
            phase_items += burst;
            repeat (burst) push_add(1'($urandom), 16'($urandom), 16'($urandom),
                                    8'($urandom), 8'($urandom));
            burst = $urandom_range(1, 3);
            phase_items += burst;
            repeat (burst) push_tick();
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
